FILE: rtl/core/rlst_pkg.sv
`default_nettype none
package rlst_pkg;

  // Field widths
  localparam int unsigned ALT_W   = 26;
  localparam int unsigned SPD_W   = 20;
  localparam int unsigned HDG_W   = 19;
  localparam int unsigned FUEL_W  = 40;
  localparam int unsigned DIST_W  = 62;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned CFG_W   = 40;
  localparam int unsigned IDX_W   = 3;

  // Shared multiplier: 23 x 31 bit operands, 54 bit product
  localparam int unsigned MUL_A_W = 23;
  localparam int unsigned MUL_B_W = 31;
  localparam int unsigned PROD_W  = 54;
  // Divide by 125 as multiply by ceil(2^37/125), keep product bits 53..37
  localparam int unsigned QUOT_LSB = 37;
  localparam int unsigned QUOT_W   = 17;
  localparam int unsigned BURN_W   = 34;
  localparam int unsigned REM_W    = 11;

  localparam logic [HDG_W-1:0]   CIRCLE      = 19'd360000;
  localparam logic [HDG_W-1:0]   HALF_CIRCLE = 19'd180000;
  localparam logic [ALT_W-1:0]   ALT_MAX     = 26'd45000000;
  localparam logic [SPD_W-1:0]   SPEED_MAX   = 20'd600000;
  localparam logic [MUL_B_W-1:0] RECIP_125   = 31'd1099511628;

  typedef enum logic [IDX_W-1:0] {
    REG_INIT_ALT  = 3'd0,
    REG_INIT_SPD  = 3'd1,
    REG_INIT_HDG  = 3'd2,
    REG_INIT_FUEL = 3'd3,
    REG_GOAL_ALT  = 3'd4,
    REG_GOAL_SPD  = 3'd5,
    REG_GOAL_HDG  = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_DIST = 3'd0,  // speed * dt
    MUL_QA   = 3'd1,  // (s >> 4) * recip
    MUL_AD   = 3'd2,  // (s / 2000) * dt
    MUL_RD   = 3'd3,  // (s % 2000) * dt
    MUL_QB   = 3'd4   // (rem * dt >> 4) * recip
  } mul_sel_e;

  typedef struct packed {
    logic [ALT_W-1:0]  init_altitude;
    logic [SPD_W-1:0]  init_speed;
    logic [HDG_W-1:0]  init_heading;
    logic [FUEL_W-1:0] init_fuel;
    logic [ALT_W-1:0]  goal_altitude;
    logic [SPD_W-1:0]  goal_speed;
    logic [HDG_W-1:0]  goal_heading;
  } cfg_t;

  typedef struct packed {
    logic     ld_restart;
    logic     ld_tick;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     dist_upd;
    logic     rem_ld;
    logic     burn_ld;
    logic     fuel_upd;
    logic     out_ld;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/rlst_cfg.sv
`default_nettype none
module rlst_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rlst_pkg::IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rlst_pkg::CFG_W-1:0]  cfg_wdata_i,
  output rlst_pkg::cfg_t                   cfg_o
);
  import rlst_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic [ALT_W-1:0] wr_alt;
  logic [SPD_W-1:0] wr_spd;
  logic [HDG_W-1:0] wr_hdg;
  logic [HDG_W-1:0] wr_hdg_wrap;

  // Saturate goals, fold headings into one turn at write time
  always_comb begin
    wr_alt      = cfg_wdata_i[ALT_W-1:0];
    wr_spd      = cfg_wdata_i[SPD_W-1:0];
    wr_hdg      = cfg_wdata_i[HDG_W-1:0];
    wr_hdg_wrap = (wr_hdg >= CIRCLE) ? wr_hdg - CIRCLE : wr_hdg;
    cfg_d       = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INIT_ALT:  cfg_d.init_altitude = wr_alt;
        REG_INIT_SPD:  cfg_d.init_speed    = wr_spd;
        REG_INIT_HDG:  cfg_d.init_heading  = wr_hdg_wrap;
        REG_INIT_FUEL: cfg_d.init_fuel     = cfg_wdata_i[FUEL_W-1:0];
        REG_GOAL_ALT:  cfg_d.goal_altitude = (wr_alt > ALT_MAX) ? ALT_MAX : wr_alt;
        REG_GOAL_SPD:  cfg_d.goal_speed    = (wr_spd > SPEED_MAX) ? SPEED_MAX : wr_spd;
        REG_GOAL_HDG:  cfg_d.goal_heading  = wr_hdg_wrap;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/core/rlst_ctrl.sv
`default_nettype none
module rlst_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic restart_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rlst_pkg::cmd_t cmd_o
);
  import rlst_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIST = 8'b0000_0010,
    ST_QA   = 8'b0000_0100,
    ST_AD   = 8'b0000_1000,
    ST_RD   = 8'b0001_0000,
    ST_QB   = 8'b0010_0000,
    ST_FUEL = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Sequence one item; a tick goes through the shared multiplier, a restart does not
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_DIST;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            cmd_o.ld_restart = 1'b1;
            state_d          = ST_DONE;
          end else begin
            cmd_o.ld_tick = 1'b1;
            state_d       = ST_DIST;
          end
        end
      end
      ST_DIST: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DIST;
        state_d       = ST_QA;
      end
      ST_QA: begin
        cmd_o.dist_upd = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_QA;
        state_d        = ST_AD;
      end
      ST_AD: begin
        cmd_o.rem_ld  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_AD;
        state_d       = ST_RD;
      end
      ST_RD: begin
        cmd_o.burn_ld = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RD;
        state_d       = ST_QB;
      end
      ST_QB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_QB;
        state_d       = ST_FUEL;
      end
      ST_FUEL: begin
        cmd_o.fuel_upd = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the output transfer
  always_comb begin
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/core/rlst_dp.sv
`default_nettype none
module rlst_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rlst_pkg::cfg_t               cfg_i,
  input  wire rlst_pkg::cmd_t               cmd_i,
  input  wire logic [rlst_pkg::DT_W-1:0]    elapsed_ms_i,
  output logic [rlst_pkg::ALT_W-1:0]        altitude_now_o,
  output logic [rlst_pkg::SPD_W-1:0]        speed_now_o,
  output logic [rlst_pkg::HDG_W-1:0]        heading_now_o,
  output logic [rlst_pkg::FUEL_W-1:0]       fuel_now_o,
  output logic [rlst_pkg::DIST_W-1:0]       distance_now_o,
  output logic                              fuel_empty_o
);
  import rlst_pkg::*;

  // Tracked state
  logic [ALT_W-1:0]   alt_q, alt_d;
  logic [SPD_W-1:0]   spd_q, spd_d;
  logic [HDG_W-1:0]   hdg_q, hdg_d;
  logic [FUEL_W-1:0]  fuel_q, fuel_d;
  logic [DIST_W-1:0]  dist_q, dist_d;

  // Work registers
  logic [DT_W-1:0]    dt_q;
  logic [PROD_W-1:0]  prod_q;
  logic [REM_W-1:0]   rem_q;
  logic [BURN_W-1:0]  burn_q;

  // Result registers
  logic [ALT_W-1:0]   alt_out_q;
  logic [SPD_W-1:0]   spd_out_q;
  logic [HDG_W-1:0]   hdg_out_q;
  logic [FUEL_W-1:0]  fuel_out_q;
  logic [DIST_W-1:0]  dist_out_q;
  logic               empty_out_q;

  logic [21:0]        alt_lim;
  logic [ALT_W-1:0]   alt_lim_x;
  logic [ALT_W-1:0]   alt_gap;
  logic [17:0]        spd_lim;
  logic [SPD_W-1:0]   spd_lim_x;
  logic [SPD_W-1:0]   spd_gap;

  logic [17:0]        turn;
  logic signed [20:0] hd_raw;
  logic [HDG_W-1:0]   hd_d;
  logic               hd_pos;
  logic [HDG_W-1:0]   hd_mag;
  logic [HDG_W:0]     hd_fwd;
  logic [HDG_W-1:0]   hd_next;

  logic [26:0]        fuel_rate;
  logic [QUOT_W-1:0]  quot;
  logic [27:0]        quot_x2000;
  logic [27:0]        rem_full;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [DIST_W:0]    dist_sum;
  logic [BURN_W:0]    burn;

  // Altitude slew, at most 33*dt
  always_comb begin
    alt_lim   = {1'b0, elapsed_ms_i, 5'b0} + {6'b0, elapsed_ms_i};
    alt_lim_x = ALT_W'(alt_lim);
    if (cfg_i.goal_altitude >= alt_q) begin
      alt_gap = cfg_i.goal_altitude - alt_q;
      alt_d   = (alt_gap <= alt_lim_x) ? cfg_i.goal_altitude : alt_q + alt_lim_x;
    end else begin
      alt_gap = alt_q - cfg_i.goal_altitude;
      alt_d   = (alt_gap <= alt_lim_x) ? cfg_i.goal_altitude : alt_q - alt_lim_x;
    end
  end

  // Speed slew, at most floor(5*dt/2)
  always_comb begin
    spd_lim   = 18'(({3'b0, elapsed_ms_i} + {1'b0, elapsed_ms_i, 2'b0}) >> 1);
    spd_lim_x = SPD_W'(spd_lim);
    if (cfg_i.goal_speed >= spd_q) begin
      spd_gap = cfg_i.goal_speed - spd_q;
      spd_d   = (spd_gap <= spd_lim_x) ? cfg_i.goal_speed : spd_q + spd_lim_x;
    end else begin
      spd_gap = spd_q - cfg_i.goal_speed;
      spd_d   = (spd_gap <= spd_lim_x) ? cfg_i.goal_speed : spd_q - spd_lim_x;
    end
  end

  // Heading: turn the shortest way, at most 3*dt, wrap on the circle
  always_comb begin
    turn   = {2'b0, elapsed_ms_i} + {1'b0, elapsed_ms_i, 1'b0};
    hd_raw = $signed({2'b0, cfg_i.goal_heading}) - $signed({2'b0, hdg_q})
           + $signed({2'b0, HALF_CIRCLE});
    if (hd_raw < 0) begin
      hd_d = HDG_W'(hd_raw + $signed({2'b0, CIRCLE}));
    end else if (hd_raw >= $signed({2'b0, CIRCLE})) begin
      hd_d = HDG_W'(hd_raw - $signed({2'b0, CIRCLE}));
    end else begin
      hd_d = HDG_W'(hd_raw);
    end
    hd_pos = (hd_d > HALF_CIRCLE);
    hd_mag = hd_pos ? hd_d - HALF_CIRCLE : HALF_CIRCLE - hd_d;
    hd_fwd = {1'b0, hdg_q} + {2'b0, turn};
    if (hd_mag <= HDG_W'(turn)) begin
      hd_next = cfg_i.goal_heading;
    end else if (hd_pos) begin
      hd_next = (hd_fwd >= {1'b0, CIRCLE}) ? HDG_W'(hd_fwd - {1'b0, CIRCLE})
                                          : HDG_W'(hd_fwd);
    end else begin
      hd_next = (hdg_q >= HDG_W'(turn)) ? hdg_q - HDG_W'(turn)
                                        : hdg_q + CIRCLE - HDG_W'(turn);
    end
    hdg_d = hd_next;
  end

  // Burn rate numerator, its quotient by 2000 from the reciprocal product, and the remainder
  always_comb begin
    fuel_rate  = 27'({spd_q, 5'b0}) + 27'({spd_q, 3'b0}) + 27'(alt_q);
    quot       = prod_q[PROD_W-1:QUOT_LSB];
    quot_x2000 = 28'(quot) * 28'd2000;
    rem_full   = 28'(fuel_rate) - quot_x2000;
  end

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_DIST: begin
        mul_a = MUL_A_W'(spd_q);
        mul_b = MUL_B_W'(dt_q);
      end
      MUL_QA: begin
        mul_a = fuel_rate[26:4];
        mul_b = RECIP_125;
      end
      MUL_AD: begin
        mul_a = MUL_A_W'(quot);
        mul_b = MUL_B_W'(dt_q);
      end
      MUL_RD: begin
        mul_a = MUL_A_W'(rem_q);
        mul_b = MUL_B_W'(dt_q);
      end
      MUL_QB: begin
        mul_a = prod_q[26:4];
        mul_b = RECIP_125;
      end
      default: ;
    endcase
  end

  // Saturating distance and floored fuel
  always_comb begin
    dist_sum = {1'b0, dist_q} + (DIST_W + 1)'(prod_q[35:0]);
    burn     = {1'b0, burn_q} + (BURN_W + 1)'(quot);
    dist_d   = dist_q;
    fuel_d   = fuel_q;
    if (cmd_i.dist_upd) begin
      dist_d = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
    end
    if (cmd_i.fuel_upd) begin
      fuel_d = (FUEL_W'(burn) >= fuel_q) ? '0 : fuel_q - FUEL_W'(burn);
    end
  end

  // Advance tracked state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_q  <= '0;
      spd_q  <= '0;
      hdg_q  <= '0;
      fuel_q <= '0;
      dist_q <= '0;
    end else if (cmd_i.ld_restart) begin
      alt_q  <= cfg_i.init_altitude;
      spd_q  <= cfg_i.init_speed;
      hdg_q  <= cfg_i.init_heading;
      fuel_q <= cfg_i.init_fuel;
      dist_q <= '0;
    end else begin
      if (cmd_i.ld_tick) begin
        alt_q <= alt_d;
        spd_q <= spd_d;
        hdg_q <= hdg_d;
      end
      fuel_q <= fuel_d;
      dist_q <= dist_d;
    end
  end

  // Work registers and the product register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_tick) begin
      dt_q <= elapsed_ms_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.rem_ld) begin
      rem_q <= rem_full[REM_W-1:0];
    end
    if (cmd_i.burn_ld) begin
      burn_q <= prod_q[BURN_W-1:0];
    end
  end

  // Capture the result for the output transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      alt_out_q   <= alt_q;
      spd_out_q   <= spd_q;
      hdg_out_q   <= hdg_q;
      fuel_out_q  <= fuel_q;
      dist_out_q  <= dist_q;
      empty_out_q <= (fuel_q == '0);
    end
  end

  assign altitude_now_o = alt_out_q;
  assign speed_now_o    = spd_out_q;
  assign heading_now_o  = hdg_out_q;
  assign fuel_now_o     = fuel_out_q;
  assign distance_now_o = dist_out_q;
  assign fuel_empty_o   = empty_out_q;

endmodule
`default_nettype wire

FILE: rtl/core/rate_limited_state_tracker.sv
`default_nettype none
// Slew-rate limited tracker for altitude, speed and heading with distance and
// fuel integration. An input transfer with restart set reloads the state from
// the init registers and clears distance; otherwise it applies one tick of
// elapsed_ms. Every input transfer yields exactly one result transfer holding
// the state after the item. A restart goes straight to the result capture;
// a tick takes the accept cycle for the three slews, then five passes through
// a single shared 23x31 multiplier (distance product, two reciprocal divisions
// by 2000 and two products with dt), then the fuel update and the result
// capture. The result capture waits until the output register is free.
// One item is in work at a time; a finished result sits in an output register,
// so the next item can be accepted while it waits. Write the configuration
// registers only while the block is idle; heading registers are folded into
// 0..359999 and goal altitude and speed are saturated on write.
module rate_limited_state_tracker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration writes
  input  wire logic                         cfg_we_i,
  input  wire logic [rlst_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rlst_pkg::CFG_W-1:0]   cfg_wdata_i,
  // Input items
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         restart_i,
  input  wire logic [rlst_pkg::DT_W-1:0]    elapsed_ms_i,
  // Result items
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [rlst_pkg::ALT_W-1:0]        altitude_now_o,
  output logic [rlst_pkg::SPD_W-1:0]        speed_now_o,
  output logic [rlst_pkg::HDG_W-1:0]        heading_now_o,
  output logic [rlst_pkg::FUEL_W-1:0]       fuel_now_o,
  output logic [rlst_pkg::DIST_W-1:0]       distance_now_o,
  output logic                              fuel_empty_o
);
  import rlst_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  rlst_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rlst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .restart_i   (restart_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rlst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .elapsed_ms_i   (elapsed_ms_i),
    .altitude_now_o (altitude_now_o),
    .speed_now_o    (speed_now_o),
    .heading_now_o  (heading_now_o),
    .fuel_now_o     (fuel_now_o),
    .distance_now_o (distance_now_o),
    .fuel_empty_o   (fuel_empty_o)
  );

endmodule
`default_nettype wire
